// File: rtl/efw_pkg.sv
// shared types, constants and the light table for the exposure fusion weight block
// no dependencies
`default_nettype none

package efw_pkg;

    localparam int unsigned MAX_WIDTH   = 4096;
    localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
    localparam int unsigned WIDTH_W     = 13;
    localparam int unsigned SQRT_STAGES = 13;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int unsigned GRAY_B     = 1868;
    localparam int unsigned GRAY_G     = 9617;
    localparam int unsigned GRAY_R     = 4899;
    localparam int unsigned GRAY_ROUND = 8192;

    localparam int unsigned SAT_RECIP = 89829381;
    localparam int unsigned SAT_DIV   = 765;
    localparam int unsigned WGT_RECIP = 32896;
    localparam int unsigned WGT_DIV   = 255;
    localparam int unsigned WGT_HALF  = 66846720;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] center_gray;
        logic [7:0] up_gray;
        logic [7:0] down_gray;
        logic [7:0] left_gray;
        logic [7:0] right_gray;
        logic       last_in_row;
        logic       last_in_frame;
    } efw_task_t;

    typedef struct packed {
        logic [15:0] weight;
        logic [9:0]  contrast;
        logic [15:0] saturation;
        logic [15:0] light;
        logic        last_in_row;
        logic        last_in_frame;
    } efw_result_t;

    typedef logic [15:0] light_lut_t [256];

    function automatic logic [7:0] gray_of(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        logic [22:0] acc;
        acc = 23'(b) * 23'(GRAY_B) + 23'(g) * 23'(GRAY_G) + 23'(r) * 23'(GRAY_R)
            + 23'(GRAY_ROUND);
        return 8'(acc >> 14);
    endfunction

    function automatic logic [15:0] light_entry(input logic [7:0] g);
        logic [63:0] dd;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] e;
        logic signed [63:0] sum;
        if (g >= 8'd128)
            dd = 64'(g) * 64'd2 - 64'd255;
        else
            dd = 64'd255 - 64'(g) * 64'd2;
        y = (((dd * dd) << 32) / 64'd20808) >> 2;
        term = 64'd1 << 32;
        sum = 64'sd1 <<< 32;
        term = ((term * y) >> 32) / 64'd1;  sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd2;  sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd3;  sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd4;  sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd5;  sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd6;  sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd7;  sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd8;  sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd9;  sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd10; sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd11; sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd12; sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd13; sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd14; sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd15; sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd16; sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd17; sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd18; sum = sum + $signed(term);
        term = ((term * y) >> 32) / 64'd19; sum = sum - $signed(term);
        term = ((term * y) >> 32) / 64'd20; sum = sum + $signed(term);
        if (sum < 0)
            sum = 64'sd0;
        e = $unsigned(sum);
        if (e > 64'hFFFF_FFFF)
            e = 64'hFFFF_FFFF;
        e = (e * e + 64'h8000_0000) >> 32;
        if (e > 64'hFFFF_FFFF)
            e = 64'hFFFF_FFFF;
        e = (e * e + 64'h8000_0000) >> 32;
        e = (e + 64'd32768) >> 16;
        return (e > 64'd65535) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic light_lut_t build_light_lut();
        light_lut_t lut;
        for (int i = 0; i < 256; i++)
        begin
            lut[i] = light_entry(8'(i));
        end
        return lut;
    endfunction

    localparam light_lut_t LIGHT_LUT = build_light_lut();

endpackage

`default_nettype wire

// File: rtl/efw_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module efw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/efw_pipe.sv
// arithmetic pipeline: laplacian, saturation square root and division, weight product
// depends on efw_pkg
`default_nettype none

module efw_pipe (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              task_valid,
    input  wire efw_pkg::efw_task_t task_data,
    output logic                   task_ready,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output efw_pkg::efw_result_t   res_data
);

    localparam int unsigned NSTG = efw_pkg::SQRT_STAGES + 9;

    typedef struct packed {
        logic [9:0]  contrast;
        logic [15:0] light;
        logic        last_in_row;
        logic        last_in_frame;
    } side_t;

    logic            en;
    logic [NSTG-1:0] vld_reg;

    efw_pkg::efw_task_t s0_reg;
    side_t              p1_side_reg;
    logic [16:0]        p1_var_reg;

    side_t       sq_side_reg [efw_pkg::SQRT_STAGES];
    logic [16:0] sq_var_reg  [efw_pkg::SQRT_STAGES];
    logic [27:0] sq_rem_reg  [efw_pkg::SQRT_STAGES];
    logic [25:0] sq_root_reg [efw_pkg::SQRT_STAGES];
    logic [27:0] sq_rem_next [efw_pkg::SQRT_STAGES];
    logic [25:0] sq_root_next[efw_pkg::SQRT_STAGES];

    side_t       k1_side_reg;
    logic [15:0] k1_q_reg;
    logic [25:0] k1_root_reg;
    side_t       k2_side_reg;
    logic [15:0] k2_sat_reg;
    side_t       m1_side_reg;
    logic [15:0] m1_sat_reg;
    logic [25:0] m1_prod_reg;
    side_t       m2_side_reg;
    logic [15:0] m2_sat_reg;
    logic [41:0] m2_prod_reg;
    side_t       d1_side_reg;
    logic [15:0] d1_sat_reg;
    logic [23:0] d1_u_reg;
    side_t       d2_side_reg;
    logic [15:0] d2_sat_reg;
    logic [23:0] d2_u_reg;
    logic [15:0] d2_q_reg;
    efw_pkg::efw_result_t out_reg;

    logic [10:0] p1_sum;
    logic [10:0] p1_diff;
    logic [9:0]  p1_con;
    logic [9:0]  p1_csum;
    logic [19:0] p1_var;
    logic [52:0] k1_prod;
    logic [26:0] k2_rem;
    logic [16:0] k2_kd;
    logic [16:0] k2_sat;
    logic [39:0] d2_prod;
    logic [23:0] o_rem;
    logic [16:0] o_wq;

    assign en         = !vld_reg[NSTG-1] || res_ready;
    assign task_ready = en;
    assign res_valid  = vld_reg[NSTG-1];
    assign res_data   = out_reg;

    always_comb
    begin
        p1_sum  = 11'(s0_reg.up_gray) + 11'(s0_reg.down_gray) + 11'(s0_reg.left_gray)
                + 11'(s0_reg.right_gray);
        p1_diff = {1'b0, s0_reg.center_gray, 2'b00} - p1_sum;
        p1_con  = p1_diff[10] ? 10'(-p1_diff) : p1_diff[9:0];
        p1_csum = 10'(s0_reg.blue) + 10'(s0_reg.green) + 10'(s0_reg.red);
        p1_var  = 20'd3 * (20'(s0_reg.blue) * 20'(s0_reg.blue)
                + 20'(s0_reg.green) * 20'(s0_reg.green) + 20'(s0_reg.red) * 20'(s0_reg.red))
                - 20'(p1_csum) * 20'(p1_csum);
    end

    // two root bits per stage
    always_comb
    begin
        logic [27:0] rem;
        logic [25:0] root;
        logic [16:0] var_in;
        logic [51:0] rad;
        logic [29:0] rem_w;
        logic [29:0] trial;
        int          p;
        for (int j = 0; j < int'(efw_pkg::SQRT_STAGES); j++)
        begin
            p = (j == 0) ? 0 : j - 1;
            if (j == 0)
            begin
                rem    = '0;
                root   = '0;
                var_in = p1_var_reg;
            end
            else
            begin
                rem    = sq_rem_reg[p];
                root   = sq_root_reg[p];
                var_in = sq_var_reg[p];
            end
            rad = {1'b0, var_in, 34'd0};
            for (int s = 0; s < 2; s++)
            begin
                rem_w = {rem, 2'(rad >> (50 - 2 * (2 * j + s)))};
                trial = {2'b00, root, 2'b01};
                if (rem_w >= trial)
                begin
                    rem  = 28'(rem_w - trial);
                    root = {root[24:0], 1'b1};
                end
                else
                begin
                    rem  = rem_w[27:0];
                    root = {root[24:0], 1'b0};
                end
            end
            sq_rem_next[j]  = rem;
            sq_root_next[j] = root;
        end
    end

    always_comb
    begin
        k1_prod = 53'(sq_root_reg[efw_pkg::SQRT_STAGES-1]) * 53'(efw_pkg::SAT_RECIP);
        k2_rem  = 27'(k1_root_reg) - 27'(k1_q_reg) * 27'(efw_pkg::SAT_DIV);
        k2_kd   = 17'(k1_q_reg) + ((k2_rem >= 27'(efw_pkg::SAT_DIV)) ? 17'd1 : 17'd0);
        k2_sat  = (k2_kd + 17'd1) >> 1;
        d2_prod = 40'(d1_u_reg) * 40'(efw_pkg::WGT_RECIP);
        o_rem   = d2_u_reg - 24'(d2_q_reg) * 24'(efw_pkg::WGT_DIV);
        o_wq    = 17'(d2_q_reg) + ((o_rem >= 24'(efw_pkg::WGT_DIV)) ? 17'd1 : 17'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], task_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= task_data;

            p1_side_reg.contrast      <= p1_con;
            p1_side_reg.light         <= efw_pkg::LIGHT_LUT[s0_reg.center_gray];
            p1_side_reg.last_in_row   <= s0_reg.last_in_row;
            p1_side_reg.last_in_frame <= s0_reg.last_in_frame;
            p1_var_reg                <= p1_var[16:0];

            sq_side_reg[0] <= p1_side_reg;
            sq_var_reg[0]  <= p1_var_reg;
            for (int j = 1; j < int'(efw_pkg::SQRT_STAGES); j++)
            begin
                sq_side_reg[j] <= sq_side_reg[j-1];
                sq_var_reg[j]  <= sq_var_reg[j-1];
            end
            for (int j = 0; j < int'(efw_pkg::SQRT_STAGES); j++)
            begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
            end

            k1_side_reg <= sq_side_reg[efw_pkg::SQRT_STAGES-1];
            k1_q_reg    <= 16'(k1_prod >> 36);
            k1_root_reg <= sq_root_reg[efw_pkg::SQRT_STAGES-1];

            k2_side_reg <= k1_side_reg;
            k2_sat_reg  <= (k2_sat > 17'd65535) ? 16'hFFFF : k2_sat[15:0];

            m1_side_reg <= k2_side_reg;
            m1_sat_reg  <= k2_sat_reg;
            m1_prod_reg <= 26'(k2_side_reg.contrast) * 26'(k2_sat_reg);

            m2_side_reg <= m1_side_reg;
            m2_sat_reg  <= m1_sat_reg;
            m2_prod_reg <= 42'(m1_prod_reg) * 42'(m1_side_reg.light);

            d1_side_reg <= m2_side_reg;
            d1_sat_reg  <= m2_sat_reg;
            d1_u_reg    <= 24'((43'(m2_prod_reg) + 43'(efw_pkg::WGT_HALF)) >> 19);

            d2_side_reg <= d1_side_reg;
            d2_sat_reg  <= d1_sat_reg;
            d2_u_reg    <= d1_u_reg;
            d2_q_reg    <= 16'(d2_prod >> 23);

            out_reg.weight        <= (o_wq > 17'd65535) ? 16'hFFFF : o_wq[15:0];
            out_reg.contrast      <= d2_side_reg.contrast;
            out_reg.saturation    <= d2_sat_reg;
            out_reg.light         <= d2_side_reg.light;
            out_reg.last_in_row   <= d2_side_reg.last_in_row;
            out_reg.last_in_frame <= d2_side_reg.last_in_frame;
        end
    end

endmodule

`default_nettype wire

// File: rtl/exposure_fusion_weight_map.sv
// top level of the exposure fusion weight block: row stores, neighbour fetch, state
// depends on efw_pkg, efw_ram and efw_pipe
`default_nettype none

// Takes one BGR pixel per clock in raster order and returns contrast, saturation,
// light and their product for the pixel one row above, so results lag one row. After a
// frame, image_width flush items (op = 1) drain the last row and mark last_in_frame.
// Two row memories with registered reads are prefetched one column ahead, with write
// forwarding, so an item is taken on every clock; the arithmetic pipeline has 22 register
// stages, and the input stalls only while a valid result at the output is not taken.
// image_width may be changed only while the block is idle; 0 acts as 1.

module exposure_fusion_weight_map (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] image_width,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      weight,
    output logic [9:0]       contrast,
    output logic [15:0]      saturation,
    output logic [15:0]      light,
    output logic             last_in_row,
    output logic             last_in_frame
);

    localparam int unsigned CW = efw_pkg::COL_W;
    localparam int unsigned WW = efw_pkg::WIDTH_W;

    logic [WW-1:0] width_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          past_first_row_reg;
    logic          past_first_row_next;
    logic          flushing_reg;
    logic          flushing_next;
    logic [7:0]    left_gray_reg;
    logic [7:0]    left_gray_next;

    logic [WW-1:0] w_eff;
    logic [WW-1:0] col_inc;
    logic          last_col;
    logic          accept;
    logic          skip;
    logic          fl;
    logic          we;
    logic [7:0]    gray_in;

    logic [CW-1:0] raddr_a;
    logic [CW-1:0] raddr_b;
    logic [39:0]   wdata_a;
    logic [39:0]   q_a;
    logic [7:0]    q_b;
    logic          fwd_a_reg;
    logic          fwd_b_reg;
    logic [39:0]   fwd_a_data_reg;
    logic [7:0]    fwd_b_data_reg;
    logic [39:0]   rd_a;
    logic [7:0]    rd_b;

    efw_pkg::efw_task_t   task_data;
    logic                 task_valid;
    efw_pkg::efw_result_t res_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        priority if (width_reg == '0)
            w_eff = WW'(1);
        else if (width_reg > WW'(efw_pkg::MAX_WIDTH))
            w_eff = WW'(efw_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
    end

    assign col_inc  = WW'(col_reg) + WW'(1);
    assign last_col = col_inc >= w_eff;
    assign accept   = in_valid && in_ready;
    assign skip     = !past_first_row_reg && (op == efw_pkg::OP_FLUSH);
    assign fl       = flushing_reg || (op == efw_pkg::OP_FLUSH);
    assign we       = accept && !skip;
    assign gray_in  = efw_pkg::gray_of(blue, green, red);

    assign rd_a = fwd_a_reg ? fwd_a_data_reg : q_a;
    assign rd_b = fwd_b_reg ? fwd_b_data_reg : q_b;

    // upper gray, middle gray, middle color
    assign wdata_a = {past_first_row_reg ? rd_a[31:24] : 8'd0, gray_in, red, green, blue};

    always_comb
    begin
        col_next            = col_reg;
        past_first_row_next = past_first_row_reg;
        flushing_next       = flushing_reg;
        left_gray_next      = left_gray_reg;
        if (we)
        begin
            col_next = last_col ? '0 : col_inc[CW-1:0];
            if (!past_first_row_reg)
            begin
                if (last_col)
                    past_first_row_next = 1'b1;
            end
            else
            begin
                left_gray_next = rd_a[31:24];
                flushing_next  = fl;
                if (last_col && fl)
                begin
                    past_first_row_next = 1'b0;
                    flushing_next       = 1'b0;
                end
            end
        end
    end

    assign raddr_a = col_next;
    assign raddr_b = col_next + CW'(1);

    always_comb
    begin
        task_data.blue          = rd_a[7:0];
        task_data.green         = rd_a[15:8];
        task_data.red           = rd_a[23:16];
        task_data.center_gray   = rd_a[31:24];
        task_data.up_gray       = rd_a[39:32];
        task_data.down_gray     = fl ? 8'd0 : gray_in;
        task_data.left_gray     = (col_reg == '0) ? 8'd0 : left_gray_reg;
        task_data.right_gray    = last_col ? 8'd0 : rd_b;
        task_data.last_in_row   = last_col;
        task_data.last_in_frame = last_col && fl;
        task_valid              = accept && past_first_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg          <= WW'(efw_pkg::MAX_WIDTH);
            col_reg            <= '0;
            past_first_row_reg <= 1'b0;
            flushing_reg       <= 1'b0;
            left_gray_reg      <= '0;
            fwd_a_reg          <= 1'b0;
            fwd_b_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                width_reg <= image_width;
            col_reg            <= col_next;
            past_first_row_reg <= past_first_row_next;
            flushing_reg       <= flushing_next;
            left_gray_reg      <= left_gray_next;
            fwd_a_reg          <= we && (col_reg == raddr_a);
            fwd_b_reg          <= we && (col_reg == raddr_b);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_a_data_reg <= wdata_a;
        fwd_b_data_reg <= gray_in;
    end

    efw_ram #(
        .WIDTH (40),
        .DEPTH (efw_pkg::MAX_WIDTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (we),
        .waddr (col_reg),
        .wdata (wdata_a),
        .raddr (raddr_a),
        .rdata (q_a)
    );

    efw_ram #(
        .WIDTH (8),
        .DEPTH (efw_pkg::MAX_WIDTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (we),
        .waddr (col_reg),
        .wdata (gray_in),
        .raddr (raddr_b),
        .rdata (q_b)
    );

    efw_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_data  (task_data),
        .task_ready (in_ready),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res_data   (res_data)
    );

    assign weight        = res_data.weight;
    assign contrast      = res_data.contrast;
    assign saturation    = res_data.saturation;
    assign light         = res_data.light;
    assign last_in_row   = res_data.last_in_row;
    assign last_in_frame = res_data.last_in_frame;

    a_flush_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> past_first_row_reg)
        else $error("flushing without a stored row");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (we && past_first_row_reg && last_col && fl)
        |=> (!past_first_row_reg && !flushing_reg && col_reg == '0))
        else $error("frame end did not clear state");

    a_ignored_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && skip) |=> ($stable(col_reg) && !past_first_row_reg))
        else $error("early flush item changed state");

endmodule

`default_nettype wire

// File: tb/efw_weight_checker.sv
// checker for exposure_fusion_weight_map: follows the cfg, input and result channels,
// predicts every result item from its own row stores and compares field by field
// depends on efw_pkg for the result struct and MAX_WIDTH
`timescale 1ns / 100ps

module efw_weight_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [12:0] image_width,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  red,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] weight,
    input  wire logic [9:0]  contrast,
    input  wire logic [15:0] saturation,
    input  wire logic [15:0] light,
    input  wire logic        last_in_row,
    input  wire logic        last_in_frame,
    output int               failures,
    output int               pending
);

    logic [15:0] light_tab [256];
    logic [7:0]  upper_gray [efw_pkg::MAX_WIDTH];
    logic [23:0] middle_bgr [efw_pkg::MAX_WIDTH];
    logic [7:0]  left_gray;
    int unsigned col;
    logic        past_first_row;
    logic        flushing;
    logic [12:0] width_reg;
    efw_pkg::efw_result_t expected_q [$];

    function automatic logic [7:0] gray_value(input logic [23:0] bgr);
        longint unsigned acc;
        acc = 64'(bgr[7:0]) * 1868 + 64'(bgr[15:8]) * 9617 + 64'(bgr[23:16]) * 4899 + 8192;
        return 8'(acc >> 14);
    endfunction

    initial
    begin
        for (int g = 0; g < 256; g++)
        begin
            longint          d;
            longint unsigned y;
            longint unsigned term;
            longint unsigned e;
            longint          sum;
            d = 2 * g - 255;
            y = ((64'(d * d) << 32) / 20808) >> 2;
            term = 64'd1 << 32;
            sum = 64'sd1 << 32;
            for (int k = 1; k <= 20; k++)
            begin
                term = ((term * y) >> 32) / k;
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            e = sum;
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
            e = (e * e + 64'h8000_0000) >> 32;
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
            e = (e * e + 64'h8000_0000) >> 32;
            e = (e + 32768) >> 16;
            light_tab[g] = (e > 65535) ? 16'hFFFF : e[15:0];
        end
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        failures++;
    endtask

    task automatic take_pixel(input logic is_flush, input logic [23:0] bgr);
        int unsigned          w;
        logic                 last_col;
        logic                 fl;
        logic [23:0]          cen_bgr;
        logic [7:0]           cen;
        int                   lap;
        longint unsigned      s;
        longint unsigned      v9;
        longint unsigned      rem;
        longint unsigned      root;
        longint unsigned      bitv;
        longint unsigned      q;
        longint unsigned      wq;
        efw_pkg::efw_result_t res;
        w = (width_reg == 0) ? 1 : (width_reg > efw_pkg::MAX_WIDTH) ? efw_pkg::MAX_WIDTH
                                                                     : width_reg;
        last_col = (col + 1 >= w);
        if (!past_first_row)
        begin
            if (is_flush)
                return;
            upper_gray[col] = 8'd0;
            middle_bgr[col] = bgr;
            if (last_col)
            begin
                col = 0;
                past_first_row = 1'b1;
            end
            else
                col++;
            return;
        end
        fl = flushing | is_flush;
        cen_bgr = middle_bgr[col];
        cen = gray_value(cen_bgr);
        lap = 4 * int'(cen) - int'(upper_gray[col]) - (fl ? 0 : int'(gray_value(bgr)))
            - ((col == 0) ? 0 : int'(left_gray))
            - (last_col ? 0 : int'(gray_value(middle_bgr[col + 1])));
        res.contrast = 10'((lap < 0) ? -lap : lap);
        s = 64'(cen_bgr[7:0]) + cen_bgr[15:8] + cen_bgr[23:16];
        v9 = 3 * (64'(cen_bgr[7:0]) * cen_bgr[7:0] + 64'(cen_bgr[15:8]) * cen_bgr[15:8]
            + 64'(cen_bgr[23:16]) * cen_bgr[23:16]) - s * s;
        rem = v9 << 34;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        q = (root / 765 + 1) >> 1;
        res.saturation = (q > 65535) ? 16'hFFFF : q[15:0];
        res.light = light_tab[cen];
        wq = (64'(res.contrast) * res.saturation * res.light + 66846720) / 133693440;
        res.weight = (wq > 65535) ? 16'hFFFF : wq[15:0];
        res.last_in_row = last_col;
        res.last_in_frame = last_col & fl;
        expected_q.insert(expected_q.size(), res);
        pending++;
        upper_gray[col] = cen;
        middle_bgr[col] = bgr;
        left_gray = cen;
        flushing = fl;
        if (last_col)
        begin
            col = 0;
            if (fl)
            begin
                past_first_row = 1'b0;
                flushing = 1'b0;
            end
        end
        else
            col++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_gray = 8'd0;
            col = 0;
            past_first_row = 1'b0;
            flushing = 1'b0;
            width_reg = 13'd4096;
            expected_q.delete();
            pending = 0;
            failures = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("unexpected result item at %0t", $realtime);
                    failures++;
                end
                else
                begin
                    efw_pkg::efw_result_t want;
                    want = expected_q.pop_front();
                    pending--;
                    if (weight !== want.weight)
                        report_mismatch("weight", weight, want.weight);
                    if (contrast !== want.contrast)
                        report_mismatch("contrast", contrast, want.contrast);
                    if (saturation !== want.saturation)
                        report_mismatch("saturation", saturation, want.saturation);
                    if (light !== want.light)
                        report_mismatch("light", light, want.light);
                    if (last_in_row !== want.last_in_row)
                        report_mismatch("last_in_row", last_in_row, want.last_in_row);
                    if (last_in_frame !== want.last_in_frame)
                        report_mismatch("last_in_frame", last_in_frame, want.last_in_frame);
                end
            end
            if (in_valid && in_ready)
                take_pixel(op, {red, green, blue});
            if (cfg_valid && cfg_ready)
                width_reg = image_width;
        end
    end

endmodule

// File: tb/tb_exposure_fusion_weight_map.sv
// testbench top for exposure_fusion_weight_map: clock, reset, pixel frames and
// flush rows with random gaps and stalls, verdict from efw_weight_checker
// depends on efw_pkg, the block and tb/efw_weight_checker.sv
`timescale 1ns / 100ps

module tb_exposure_fusion_weight_map;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] image_width;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] weight;
    logic [9:0]  contrast;
    logic [15:0] saturation;
    logic [15:0] light;
    logic        last_in_row;
    logic        last_in_frame;
    int          failures;
    int          pending;
    bit          calm;
    bit          long_stall_done;
    int          hold_req;
    int          stall_left;
    int          quiet_cycles;
    int          sent;

    exposure_fusion_weight_map uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .image_width(image_width),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .blue(blue), .green(green), .red(red),
        .out_valid(out_valid), .out_ready(out_ready),
        .weight(weight), .contrast(contrast), .saturation(saturation), .light(light),
        .last_in_row(last_in_row), .last_in_frame(last_in_frame)
    );

    efw_weight_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .image_width(image_width),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .blue(blue), .green(green), .red(red),
        .out_valid(out_valid), .out_ready(out_ready),
        .weight(weight), .contrast(contrast), .saturation(saturation), .light(light),
        .last_in_row(last_in_row), .last_in_frame(last_in_frame),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver side
    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic is_flush, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op = is_flush;
        blue = b;
        green = g;
        red = r;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_pixel();
        logic [7:0] c [3];
        for (int i = 0; i < 3; i++)
            c[i] = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                               : 8'($urandom);
        send_item(efw_pkg::OP_PIXEL, c[0], c[1], c[2]);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_width(input logic [12:0] value);
        drain();
        image_width = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // rows of pixels then a flush row; a mixed flush row starts flushing partway in
    task automatic send_frame(input logic [12:0] reg_value, input int rows, input bit mixed);
        int w;
        int k;
        write_width(reg_value);
        w = (reg_value == 0) ? 1 : (reg_value > efw_pkg::MAX_WIDTH) ? efw_pkg::MAX_WIDTH
                                                                     : reg_value;
        if ($urandom_range(0, 5) == 0)
            send_item(efw_pkg::OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (rows * w) send_pixel();
        k = mixed ? $urandom_range(0, w - 1) : 0;
        for (int i = 0; i < w; i++)
        begin
            if (i < k)
                send_pixel();
            else if (i == k)
                send_item(efw_pkg::OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int rows;
        int wv;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        image_width = 13'd0;
        in_valid = 1'b0;
        op = efw_pkg::OP_PIXEL;
        blue = 8'd0;
        green = 8'd0;
        red = 8'd0;
        calm = 1'b0;
        long_stall_done = 1'b0;
        hold_req = 0;
        quiet_cycles = 0;
        sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // width register zero acts as one, stray flush before any row
        write_width(13'd0);
        send_item(efw_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        send_item(efw_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(efw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(efw_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);
        // pure channels and a mixed flush row
        write_width(13'd3);
        send_item(efw_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h00);
        send_item(efw_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00);
        send_item(efw_pkg::OP_PIXEL, 8'h00, 8'h00, 8'hFF);
        send_item(efw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'h00);
        send_item(efw_pkg::OP_PIXEL, 8'h80, 8'h80, 8'h80);
        send_item(efw_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'hFF);
        send_item(efw_pkg::OP_PIXEL, 8'h10, 8'hE0, 8'h40);
        send_item(efw_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(efw_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        // width shrinks in the middle of a row
        write_width(13'd6);
        repeat (9) send_pixel();
        write_width(13'd2);
        send_pixel();
        send_pixel();
        send_pixel();
        send_item(efw_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(efw_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);

        // register above the store size, then the row is cut short
        write_width(13'h1FFF);
        repeat (5) send_pixel();
        write_width(13'd6);
        repeat (7) send_pixel();
        repeat (6) send_item(efw_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);

        sent = 0;
        while (sent < 1250)
        begin
            calm = ($urandom_range(0, 4) == 0);
            rows = $urandom_range(1, 5);
            case ($urandom_range(0, 19))
                0: wv = 0;
                1, 2, 3: wv = $urandom_range(20, 64);
                default: wv = $urandom_range(1, 12);
            endcase
            if (!long_stall_done && sent > 400)
            begin
                // long receiver stall while the sender keeps offering items
                long_stall_done = 1'b1;
                calm = 1'b1;
                hold_req = 400;
                send_frame(13'd16, 6, 1'b0);
            end
            else
                send_frame(13'(wv), rows, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0)
                drain();
        end
        calm = 1'b0;

        drain();
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: exposure_fusion_weight_map.f
rtl/efw_pkg.sv
rtl/efw_ram.sv
rtl/efw_pipe.sv
rtl/exposure_fusion_weight_map.sv
tb/efw_weight_checker.sv
tb/tb_exposure_fusion_weight_map.sv
